// ===== hdl/rtp_header_and_extension_parser_macros.svh =====
// Assertion macros for the RTP header parser.
// Expect clk and arst_n in the scope of each use.
`ifndef RTP_HEADER_AND_EXTENSION_PARSER_MACROS_SVH
`define RTP_HEADER_AND_EXTENSION_PARSER_MACROS_SVH
// same-cycle implication
`define RHP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define RHP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== hdl/rhp_pkg.sv =====
// Types and constants of the RTP header parser.
// No dependencies.
`default_nettype none
package rhp_pkg;
	localparam int unsigned MaxBytes = 2048;
	localparam logic [11:0] MAX_BYTES = 12'(MaxBytes);

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_ONE_ID = 2'd1;
	localparam logic [1:0] PH_TWO_ID = 2'd2;
	localparam logic [1:0] PH_TWO_LEN = 2'd3;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_TOO_LARGE   = 3'd1;
	localparam logic [2:0] ST_TOO_SHORT   = 3'd2;
	localparam logic [2:0] ST_NO_PAYLOAD  = 3'd3;
	localparam logic [2:0] ST_PAD_ERROR   = 3'd4;
	localparam logic [2:0] ST_BAD_PROFILE = 3'd5;
	localparam logic [2:0] ST_OVERRUN     = 3'd6;

	localparam logic [15:0] PROF_ONE_BYTE = 16'hBEDE;
	localparam logic [15:0] PROF_TWO_MASK = 16'hFFF0;
	localparam logic [15:0] PROF_TWO_BYTE = 16'h1000;
	localparam logic [3:0]  ID_STOP       = 4'hF;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_packet;
	} byte_req_t;

	typedef struct packed {
		logic        result_kind;
		logic [2:0]  status;
		logic [7:0]  element_id;
		logic [10:0] byte_offset;
		logic [11:0] byte_length;
		logic [7:0]  pad_length;
		logic        marker;
		logic [6:0]  payload_type;
		logic [15:0] sequence_res;
		logic [31:0] timestamp;
		logic [31:0] ssrc;
		logic        last_result;
	} result_req_t;
endpackage
`default_nettype wire

// ===== hdl/rtp_header_and_extension_parser.sv =====
// Bytes pass the input register, then the result queue; one per cycle while the queue has room.
// A byte closing a packet with an element gives two results; a 4-entry result queue absorbs them.
// The input register advances only when the queue has room for two results.
// Reset (arst_n low, asynchronous) clears the queue, the input stage and all packet state.
// End of packet clears packet state; the next byte starts a new packet.
`default_nettype none
`include "rtp_header_and_extension_parser_macros.svh"
module rtp_header_and_extension_parser (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 byte_valid,
	output logic                      byte_stall,
	input  wire rhp_pkg::byte_req_t   byte_req,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output rhp_pkg::result_req_t      result_req
);
	import rhp_pkg::*;

	logic        valid_s1;
	byte_req_t   req_s1;
	logic        advance;

	logic [11:0] count_q, count_n;
	logic [31:0] hb_q [3];
	logic [31:0] hb_n [3];
	logic [6:0]  hend_q, hend_n;
	logic [31:0] eh_q, eh_n;
	logic [18:0] eend_q, eend_n;
	logic [1:0]  phase_q, phase_n;
	logic [8:0]  skip_q, skip_n;
	logic        stop_q, stop_n;
	logic [2:0]  err_q, err_n;
	logic [7:0]  held_q, held_n;

	result_req_t fifo_q [4];
	logic [1:0]  head_q, tail_q;
	logic [2:0]  fcnt_q;
	logic        pop;

	result_req_t el_res, sum_res;
	logic        el_push;

	logic [7:0]  b;
	logic [11:0] pos;
	logic [18:0] pos1;
	logic [4:0]  l1;
	logic [1:0]  eidx;
	logic [15:0] prof;
	logic [2:0]  st;
	logic [18:0] p;
	logic [11:0] plen;
	logic [7:0]  pad;

	assign advance      = valid_s1 && (fcnt_q <= 3'd2);
	assign byte_stall   = valid_s1 && !advance;
	assign result_valid = (fcnt_q != 3'd0);
	assign result_req   = fifo_q[head_q];
	assign pop          = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			req_s1 <= byte_req;
		end
	end

	always_comb begin
		b       = req_s1.data_byte;
		pos     = count_q;
		pos1    = {7'd0, pos} + 19'd1;
		l1      = {1'b0, b[3:0]} + 5'd1;
		count_n = count_q;
		hb_n    = hb_q;
		hend_n  = hend_q;
		eh_n    = eh_q;
		eend_n  = eend_q;
		phase_n = phase_q;
		skip_n  = skip_q;
		stop_n  = stop_q;
		err_n   = err_q;
		held_n  = held_q;
		el_push = 1'b0;
		el_res  = '0;
		eidx    = 2'd0;
		prof    = 16'd0;

		// extension element walk
		if (phase_q != PH_IDLE && !stop_q && {7'd0, pos} < eend_q && pos < MAX_BYTES) begin
			if (skip_q != 9'd0) begin
				skip_n = skip_q - 9'd1;
			end else if (phase_q == PH_ONE_ID) begin
				if (b[7:4] == ID_STOP) begin
					stop_n = 1'b1;
				end else if (b[7:4] != 4'd0) begin
					if (pos1 + {14'd0, l1} > eend_q) begin
						if (err_q == ST_OK) err_n = ST_OVERRUN;
						stop_n = 1'b1;
					end else begin
						el_push            = 1'b1;
						el_res.element_id  = {4'd0, b[7:4]};
						el_res.byte_offset = pos1[10:0];
						el_res.byte_length = {7'd0, l1};
						skip_n             = {4'd0, l1};
					end
				end
			end else if (phase_q == PH_TWO_ID) begin
				if (b != 8'd0 && pos1 < eend_q) begin
					held_n  = b;
					phase_n = PH_TWO_LEN;
				end
			end else begin
				phase_n = PH_TWO_ID;
				if (pos1 + {11'd0, b} > eend_q) begin
					if (err_q == ST_OK) err_n = ST_OVERRUN;
					stop_n = 1'b1;
				end else begin
					el_push            = 1'b1;
					el_res.element_id  = held_q;
					el_res.byte_offset = pos1[10:0];
					el_res.byte_length = {4'd0, b};
					skip_n             = {1'b0, b};
				end
			end
		end

		// fixed header capture
		if (pos < 12'd12) begin
			case (pos[1:0])
				2'd0: hb_n[pos[3:2]][31:24] = b;
				2'd1: hb_n[pos[3:2]][23:16] = b;
				2'd2: hb_n[pos[3:2]][15:8]  = b;
				default: hb_n[pos[3:2]][7:0] = b;
			endcase
			if (pos == 12'd0) hend_n = 7'd12 + {1'b0, b[3:0], 2'b00};
		end

		// extension header capture
		if (hb_q[0][28] && pos >= 12'd12 && pos >= {5'd0, hend_q}
				&& pos < {5'd0, hend_q} + 12'd4) begin
			eidx = pos[1:0] - hend_q[1:0];
			case (eidx)
				2'd0: eh_n[31:24] = b;
				2'd1: eh_n[23:16] = b;
				2'd2: eh_n[15:8]  = b;
				default: eh_n[7:0] = b;
			endcase
			if (eidx == 2'd3) begin
				prof   = eh_n[31:16];
				eend_n = {12'd0, hend_q} + 19'd4 + {1'b0, eh_n[15:0], 2'b00};
				if (prof == PROF_ONE_BYTE) begin
					phase_n = PH_ONE_ID;
				end else if ((prof & PROF_TWO_MASK) == PROF_TWO_BYTE) begin
					phase_n = PH_TWO_ID;
				end else if (err_n == ST_OK) begin
					err_n = ST_BAD_PROFILE;
				end
			end
		end

		if (count_q <= MAX_BYTES) count_n = count_q + 12'd1;

		// end-of-packet summary
		st   = ST_OK;
		p    = {12'd0, hend_n};
		plen = 12'd0;
		pad  = 8'd0;
		if (count_n > MAX_BYTES) begin
			st = ST_TOO_LARGE;
		end else if (count_n < 12'd12) begin
			st = ST_TOO_SHORT;
		end else begin
			if (hb_n[0][28]) begin
				if ({7'd0, count_n} < {12'd0, hend_n} + 19'd4) begin
					st = ST_TOO_SHORT;
				end else begin
					p = eend_n;
					if ({7'd0, count_n} < p) st = ST_TOO_SHORT;
				end
			end
			if (st == ST_OK && {7'd0, count_n} <= p) st = ST_NO_PAYLOAD;
			if (st == ST_OK) begin
				plen = count_n - p[11:0];
				if (hb_n[0][29]) begin
					pad = b;
					if (pad != 8'd0) begin
						if (plen <= {4'd0, pad}) begin
							st   = ST_PAD_ERROR;
							plen = 12'd0;
						end else begin
							plen = plen - {4'd0, pad};
						end
					end
				end
			end
			if (st == ST_OK) st = err_n;
		end
		if (st == ST_TOO_LARGE || st == ST_TOO_SHORT || st == ST_NO_PAYLOAD) begin
			p    = 19'd0;
			plen = 12'd0;
			pad  = 8'd0;
		end
		sum_res              = '0;
		sum_res.result_kind  = 1'b1;
		sum_res.status       = st;
		sum_res.byte_offset  = p[10:0];
		sum_res.byte_length  = plen;
		sum_res.pad_length   = pad;
		sum_res.marker       = hb_n[0][23];
		sum_res.payload_type = hb_n[0][22:16];
		sum_res.sequence_res = hb_n[0][15:0];
		sum_res.timestamp    = hb_n[1];
		sum_res.ssrc         = hb_n[2];
		sum_res.last_result  = 1'b1;
		el_res.last_result   = !req_s1.end_of_packet;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			hb_q    <= '{default: '0};
			hend_q  <= '0;
			eh_q    <= '0;
			eend_q  <= '0;
			phase_q <= PH_IDLE;
			skip_q  <= '0;
			stop_q  <= 1'b0;
			err_q   <= ST_OK;
			held_q  <= '0;
		end else if (advance) begin
			if (req_s1.end_of_packet) begin
				count_q <= '0;
				hb_q    <= '{default: '0};
				hend_q  <= '0;
				eh_q    <= '0;
				eend_q  <= '0;
				phase_q <= PH_IDLE;
				skip_q  <= '0;
				stop_q  <= 1'b0;
				err_q   <= ST_OK;
				held_q  <= '0;
			end else begin
				count_q <= count_n;
				hb_q    <= hb_n;
				hend_q  <= hend_n;
				eh_q    <= eh_n;
				eend_q  <= eend_n;
				phase_q <= phase_n;
				skip_q  <= skip_n;
				stop_q  <= stop_n;
				err_q   <= err_n;
				held_q  <= held_n;
			end
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (advance) begin
			if (el_push) begin
				fifo_q[tail_q] <= el_res;
				if (req_s1.end_of_packet) fifo_q[tail_q + 2'd1] <= sum_res;
			end else if (req_s1.end_of_packet) begin
				fifo_q[tail_q] <= sum_res;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fcnt_q <= '0;
		end else begin
			if (pop) head_q <= head_q + 2'd1;
			if (advance) begin
				tail_q <= tail_q + {1'b0, el_push} + {1'b0, req_s1.end_of_packet};
			end
			fcnt_q <= fcnt_q
				+ (advance ? ({2'd0, el_push} + {2'd0, req_s1.end_of_packet}) : 3'd0)
				- {2'd0, pop};
		end
	end

	`RHP_ASSERT_NOW(a_queue_bound, 1'b1, fcnt_q <= 3'd4, "result queue overflow")
	`RHP_ASSERT_NOW(a_summary_last, result_valid && result_req.result_kind,
		result_req.last_result, "summary not marked last")
	`RHP_ASSERT_NOW(a_element_id, result_valid && !result_req.result_kind,
		result_req.element_id != 8'd0, "element with zero id")
	`RHP_ASSERT_NEXT(a_eop_clears, advance && req_s1.end_of_packet,
		count_q == 12'd0 && phase_q == PH_IDLE, "packet state not cleared")
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for rtp_header_and_extension_parser: sends RTP packets byte by byte and
// checks every element and summary request against a built-in packet parser model.
// Depends on rhp_pkg and the parser RTL only.
`timescale 1ns / 1ps
module tb_top;
	import rhp_pkg::*;

	localparam int IDLE_LIMIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	byte_req_t   byte_req = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_req_t result_req;

	rtp_header_and_extension_parser dut (
		.clk(clk), .arst_n(arst_n),
		.byte_valid(byte_valid), .byte_stall(byte_stall), .byte_req(byte_req),
		.result_valid(result_valid), .result_stall(result_stall), .result_req(result_req)
	);

	always #2 clk = ~clk;

	// parser model state
	int          seen_bytes, hdr_end, ext_end, skip_left;
	logic [31:0] hdr_words [3];
	logic [31:0] ext_word;
	logic [1:0]  walk_phase;
	bit          walk_done;
	logic [2:0]  walk_error;
	logic [7:0]  held_elem_id;

	result_req_t parsed_results[$];
	logic [7:0]  packet_bytes[$];
	logic [7:0]  fixed_ext[$];
	int          mismatches = 0;
	int          hold_cycles = 0;
	bit          steady = 1'b0;
	int          idle_run = 0;

	task automatic clear_packet_state();
		seen_bytes = 0; hdr_end = 0; ext_end = 0; skip_left = 0;
		hdr_words[0] = '0; hdr_words[1] = '0; hdr_words[2] = '0;
		ext_word = '0; walk_phase = PH_IDLE; walk_done = 1'b0;
		walk_error = ST_OK; held_elem_id = '0;
	endtask

	task automatic push_element(logic [7:0] id, int offs, int len);
		result_req_t r;
		r = '0;
		r.status = ST_OK;
		r.element_id = id;
		r.byte_offset = 11'(offs);
		r.byte_length = 12'(len);
		parsed_results.push_back(r);
	endtask

	task automatic flag_overrun();
		if (walk_error == ST_OK) walk_error = ST_OVERRUN;
		walk_done = 1'b1;
	endtask

	task automatic parse_byte(logic [7:0] b, logic eop);
		int pos, n, p, plen, pad, l, first;
		logic [2:0] st;
		logic [15:0] prof;
		result_req_t r;
		pos = seen_bytes;
		first = parsed_results.size();
		if (walk_phase != PH_IDLE && !walk_done && pos < ext_end && pos < MaxBytes) begin
			if (skip_left > 0) begin
				skip_left--;
			end else if (walk_phase == PH_ONE_ID) begin
				if (b[7:4] == ID_STOP) begin
					walk_done = 1'b1;
				end else if (b[7:4] != 0) begin
					l = b[3:0] + 1;
					if (pos + 1 + l > ext_end) flag_overrun();
					else begin
						push_element({4'h0, b[7:4]}, pos + 1, l);
						skip_left = l;
					end
				end
			end else if (walk_phase == PH_TWO_ID) begin
				if (b != 0 && pos + 1 < ext_end) begin
					held_elem_id = b;
					walk_phase = PH_TWO_LEN;
				end
			end else begin
				walk_phase = PH_TWO_ID;
				if (pos + 1 + b > ext_end) flag_overrun();
				else begin
					push_element(held_elem_id, pos + 1, b);
					skip_left = b;
				end
			end
		end
		if (pos < 12) begin
			hdr_words[pos >> 2][8 * (3 - (pos & 3)) +: 8] = b;
			if (pos == 0) hdr_end = 12 + 4 * b[3:0];
		end
		if (hdr_words[0][28] && pos >= 12 && pos >= hdr_end && pos < hdr_end + 4) begin
			ext_word[8 * (3 - (pos - hdr_end)) +: 8] = b;
			if (pos == hdr_end + 3) begin
				prof = ext_word[31:16];
				ext_end = hdr_end + 4 + 4 * ext_word[15:0];
				if (prof == PROF_ONE_BYTE) walk_phase = PH_ONE_ID;
				else if ((prof & PROF_TWO_MASK) == PROF_TWO_BYTE) walk_phase = PH_TWO_ID;
				else if (walk_error == ST_OK) walk_error = ST_BAD_PROFILE;
			end
		end
		if (seen_bytes <= MaxBytes) seen_bytes++;
		if (eop) begin
			n = seen_bytes; p = hdr_end; plen = 0; pad = 0; st = ST_OK;
			if (n > MaxBytes) st = ST_TOO_LARGE;
			else if (n < 12) st = ST_TOO_SHORT;
			else begin
				if (hdr_words[0][28]) begin
					if (n < p + 4) st = ST_TOO_SHORT;
					else begin
						p = ext_end;
						if (n < p) st = ST_TOO_SHORT;
					end
				end
				if (st == ST_OK && n <= p) st = ST_NO_PAYLOAD;
				if (st == ST_OK) begin
					plen = n - p;
					if (hdr_words[0][29]) begin
						pad = b;
						if (pad > 0) begin
							if (plen <= pad) begin
								st = ST_PAD_ERROR;
								plen = 0;
							end else plen -= pad;
						end
					end
				end
				if (st == ST_OK) st = walk_error;
			end
			if (st == ST_TOO_LARGE || st == ST_TOO_SHORT || st == ST_NO_PAYLOAD) begin
				p = 0; plen = 0; pad = 0;
			end
			r = '0;
			r.result_kind = 1'b1;
			r.status = st;
			r.byte_offset = 11'(p);
			r.byte_length = 12'(plen);
			r.pad_length = 8'(pad);
			r.marker = hdr_words[0][23];
			r.payload_type = hdr_words[0][22:16];
			r.sequence_res = hdr_words[0][15:0];
			r.timestamp = hdr_words[1];
			r.ssrc = hdr_words[2];
			parsed_results.push_back(r);
			clear_packet_state();
		end
		if (parsed_results.size() > first)
			parsed_results[parsed_results.size() - 1].last_result = 1'b1;
	endtask

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	task automatic check_result(result_req_t got);
		result_req_t w;
		if (parsed_results.size() == 0) begin
			report("unexpected request", got.result_kind, 0);
			return;
		end
		w = parsed_results.pop_front();
		if (got.result_kind !== w.result_kind) report("result_kind", got.result_kind, w.result_kind);
		if (got.status !== w.status) report("status", got.status, w.status);
		if (got.element_id !== w.element_id) report("element_id", got.element_id, w.element_id);
		if (got.byte_offset !== w.byte_offset) report("byte_offset", got.byte_offset, w.byte_offset);
		if (got.byte_length !== w.byte_length) report("byte_length", got.byte_length, w.byte_length);
		if (got.pad_length !== w.pad_length) report("pad_length", got.pad_length, w.pad_length);
		if (got.marker !== w.marker) report("marker", got.marker, w.marker);
		if (got.payload_type !== w.payload_type)
			report("payload_type", got.payload_type, w.payload_type);
		if (got.sequence_res !== w.sequence_res)
			report("sequence_res", got.sequence_res, w.sequence_res);
		if (got.timestamp !== w.timestamp) report("timestamp", got.timestamp, w.timestamp);
		if (got.ssrc !== w.ssrc) report("ssrc", got.ssrc, w.ssrc);
		if (got.last_result !== w.last_result) report("last_result", got.last_result, w.last_result);
	endtask

	function automatic int pick_gap();
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_byte(logic [7:0] b, logic eop);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			byte_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid = 1'b1;
		byte_req.data_byte = b;
		byte_req.end_of_packet = eop;
		do @(posedge clk); while (byte_stall);
		parse_byte(b, eop);
	endtask

	task automatic send_packet();
		foreach (packet_bytes[i]) send_byte(packet_bytes[i], i == packet_bytes.size() - 1);
	endtask

	task automatic fill_elements(int kind, int left);
		int r, l;
		logic [3:0] id;
		while (left > 0) begin
			r = $urandom_range(0, 99);
			if (r < 10 || kind == 2) begin
				packet_bytes.push_back(r < 10 ? 8'h00 : 8'($urandom));
				left--;
			end else if (kind == 0) begin
				id = r < 14 ? ID_STOP : (r < 18 ? 4'h0 : 4'($urandom_range(1, 14)));
				l = $urandom_range(0, 15);
				packet_bytes.push_back({id, 4'(l)});
				left--;
				repeat (l + 1 < left ? l + 1 : left) begin
					packet_bytes.push_back(8'($urandom));
					left--;
				end
			end else begin
				packet_bytes.push_back(8'($urandom_range(1, 255)));
				left--;
				if (left == 0) break;
				l = r > 96 ? $urandom_range(0, 255) : $urandom_range(0, left > 8 ? 8 : left);
				packet_bytes.push_back(8'(l));
				left--;
				repeat (l < left ? l : left) begin
					packet_bytes.push_back(8'($urandom));
					left--;
				end
			end
		end
	endtask

	// kind: 0 one-byte profile, 1 two-byte profile, 2 unknown profile
	task automatic build_packet(int cc, bit ext, int kind, int words, bit pbit,
			int pay_len, int pad_len, int cut);
		logic [15:0] prof;
		packet_bytes.delete();
		packet_bytes.push_back({2'b10, pbit, ext, 4'(cc)});
		repeat (11) packet_bytes.push_back(8'($urandom));
		repeat (4 * cc) packet_bytes.push_back(8'($urandom));
		if (ext) begin
			if (kind == 0) prof = PROF_ONE_BYTE;
			else if (kind == 1) prof = PROF_TWO_BYTE | 16'($urandom_range(0, 15));
			else begin
				do prof = 16'($urandom);
				while (prof == PROF_ONE_BYTE || (prof & PROF_TWO_MASK) == PROF_TWO_BYTE);
			end
			packet_bytes.push_back(prof[15:8]);
			packet_bytes.push_back(prof[7:0]);
			packet_bytes.push_back(8'(words >> 8));
			packet_bytes.push_back(8'(words));
			if (fixed_ext.size() > 0) begin
				foreach (fixed_ext[i]) packet_bytes.push_back(fixed_ext[i]);
				fixed_ext.delete();
			end else fill_elements(kind, 4 * words);
		end
		repeat (pay_len) packet_bytes.push_back(8'($urandom));
		if (pbit) begin
			repeat (pad_len > 0 ? pad_len - 1 : 0) packet_bytes.push_back(8'($urandom));
			packet_bytes.push_back(8'(pad_len));
		end
		if (cut > 0 && cut < packet_bytes.size())
			while (packet_bytes.size() > cut) void'(packet_bytes.pop_back());
		send_packet();
	endtask

	task automatic test_short_packets();
		build_packet(0, 0, 0, 0, 0, 0, 0, 1);
		build_packet(0, 0, 0, 0, 0, 0, 0, 11);
		build_packet(0, 0, 0, 0, 0, 0, 0, 0);
		build_packet(3, 1, 0, 2, 0, 5, 0, 18);
		build_packet(0, 1, 1, 3, 0, 5, 0, 20);
	endtask

	task automatic test_extreme_bytes();
		packet_bytes.delete();
		repeat (100) packet_bytes.push_back(8'hFF);
		send_packet();
		packet_bytes.delete();
		repeat (40) packet_bytes.push_back(8'h00);
		send_packet();
	endtask

	task automatic test_one_byte_elements();
		fixed_ext = '{8'h00, 8'h10, 8'hAA, 8'h0F, 8'h21, 8'h01, 8'h02, 8'h03,
			8'hF0, 8'h55, 8'h66, 8'h77};
		build_packet(2, 1, 0, 3, 0, 8, 0, 0);
		fixed_ext = '{8'h3F, 8'h01, 8'h02, 8'h03};
		build_packet(0, 1, 0, 1, 0, 4, 0, 0);
		fixed_ext = '{8'hE3, 8'h01, 8'h02, 8'h03};
		build_packet(0, 1, 0, 1, 1, 6, 2, 0);
	endtask

	task automatic test_two_byte_elements();
		fixed_ext = '{8'h05, 8'h00, 8'h07, 8'h02, 8'hAB, 8'hCD, 8'h00, 8'h09};
		build_packet(1, 1, 1, 2, 0, 3, 0, 0);
		fixed_ext = '{8'hFF, 8'h09, 8'h01, 8'h02};
		build_packet(0, 1, 1, 1, 0, 3, 0, 0);
		fixed_ext = '{8'h00, 8'h00, 8'h00, 8'h00};
		build_packet(0, 1, 1, 1, 0, 3, 0, 0);
	endtask

	task automatic test_status_cases();
		build_packet(0, 0, 0, 0, 1, 10, 3, 0);
		build_packet(0, 0, 0, 0, 1, 0, 200, 0);
		build_packet(0, 0, 0, 0, 1, 4, 0, 0);
		build_packet(15, 1, 2, 1, 0, 4, 0, 0);
		build_packet(0, 1, 0, 0, 0, 0, 0, 0);
		build_packet(0, 1, 1, 2, 1, 3, 1, 0);
	endtask

	task automatic test_size_limits();
		build_packet(0, 0, 0, 0, 0, MaxBytes - 12, 0, 0);
		build_packet(0, 0, 0, 0, 1, MaxBytes - 12, 255, 0);
		build_packet(0, 1, 0, 600, 0, 10, 0, 0);
		build_packet(0, 1, 1, 520, 0, 0, 0, 2060);
	endtask

	task automatic random_packet();
		int cc, kind, r;
		cc = $urandom_range(0, 9) < 7 ? 0 : $urandom_range(0, 15);
		r = $urandom_range(0, 99);
		kind = r < 45 ? 0 : (r < 90 ? 1 : 2);
		build_packet(cc, $urandom_range(0, 9) < 8, kind, $urandom_range(0, 6),
			$urandom_range(0, 3) == 0, $urandom_range(0, 20), $urandom_range(0, 24),
			$urandom_range(0, 9) == 0 ? $urandom_range(1, 60) : 0);
	endtask

	task automatic test_random_packets();
		int sent;
		sent = 0;
		while (sent < 400) begin
			steady = $urandom_range(0, 9) == 0;
			random_packet();
			sent += packet_bytes.size();
		end
		steady = 1'b0;
	endtask

	task automatic test_backpressure();
		hold_cycles = 300;
		steady = 1'b1;
		repeat (4) random_packet();
		steady = 1'b0;
	endtask

	// receiver: random stalls plus an optional long hold
	initial begin
		int stall_left, r;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				result_stall = 1'b1;
			end else begin
				if (stall_left == 0 && !steady) begin
					r = $urandom_range(0, 99);
					if (r < 15) stall_left = $urandom_range(1, 3);
					else if (r < 18) stall_left = $urandom_range(10, 40);
				end
				result_stall = stall_left > 0;
				if (stall_left > 0) stall_left--;
			end
		end
	end

	always @(posedge clk)
		if (arst_n && result_valid && !result_stall) check_result(result_req);

	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (result_valid && !result_stall))
			idle_run <= 0;
		else if (idle_run >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end else idle_run <= idle_run + 1;
	end

	initial begin
		clear_packet_state();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		test_short_packets();
		test_extreme_bytes();
		test_one_byte_elements();
		test_two_byte_elements();
		test_status_cases();
		test_size_limits();
		test_random_packets();
		test_backpressure();
		test_random_packets();
		@(negedge clk);
		byte_valid = 1'b0;
		while (parsed_results.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule
